// ===== rtl/rptw_pkg.sv =====
// Shared types and constants for the rotated pixel trilinear weight block.
// No dependencies; used by every module under rtl/.
package rptw_pkg;

  // configuration register indexes
  typedef enum logic [3:0] {
    REG_QUAT_W   = 4'd0,
    REG_QUAT_X   = 4'd1,
    REG_QUAT_Y   = 4'd2,
    REG_QUAT_Z   = 4'd3,
    REG_CENTER_X = 4'd4,
    REG_CENTER_Y = 4'd5,
    REG_CENTER_Z = 4'd6,
    REG_GATE     = 4'd7
  } reg_idx_t;

  // input operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;
  localparam int OUT_DEPTH   = 4;
  localparam int OUT_AW      = 2;
  // box coordinates are carried at the widest size the half side allows
  localparam int COORD_MAX_W = 6;

  // one entry between front and back: a map load or a classified pixel
  typedef struct packed {
    logic                   is_load;
    logic [11:0]            addr;
    logic signed [12:0]     val;
    logic                   rej;
    logic [2:0][COORD_MAX_W-1:0] c0;   // low corner coordinate per axis
    logic [2:0]             ok_lo;     // low corner inside the box per axis
    logic [2:0]             ok_hi;     // high corner inside the box per axis
    logic [2:0][15:0]       frac;
  } qent_t;

  typedef struct packed {
    logic        hit;
    logic [11:0] voxel_id;
    logic [16:0] weight;
    logic [2:0]  corner;
    logic        last;
  } res_t;

  // clamp to [-2^31, 2^31]
  function automatic logic signed [32:0] sat_entry(input logic signed [36:0] v);
    logic signed [32:0] r;
    if (v < -37'sd2147483648) r = -33'sd2147483648;
    else if (v > 37'sd2147483648) r = 33'sd2147483648;
    else r = v[32:0];
    return r;
  endfunction

  // clamp to signed 32 bits
  function automatic logic signed [31:0] sat_word(input logic signed [36:0] v);
    logic signed [31:0] r;
    if (v < -37'sd2147483648) r = 32'sh80000000;
    else if (v > 37'sd2147483647) r = 32'sh7fffffff;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== rtl/rptw_front.sv =====
// Front end: configuration registers, rotation matrix, pixel rotation and gate test.
// Depends on rptw_pkg; pushes loads and classified pixels into rptw_queue.
module rptw_front #(
  parameter int HALF_SIDE = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic [3:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               operation,
  input  logic [11:0]        map_address,
  input  logic signed [12:0] map_value,
  input  logic signed [31:0] pix_x,
  input  logic signed [31:0] pix_y,
  input  logic signed [31:0] pix_z,
  output logic               q_push,
  output rptw_pkg::qent_t    q_data,
  input  logic               q_full
);
  import rptw_pkg::*;

  localparam int NSTG = 5;
  localparam int CW = $clog2(2 * HALF_SIDE + 1);

  typedef struct packed {
    logic               valid;
    logic               is_load;
    logic [11:0]        addr;
    logic signed [12:0] val;
  } fctl_t;

  logic signed [31:0] qw, qx, qy, qz;
  logic signed [31:0] cen [3];
  logic [31:0]        gate;
  logic [1:0]         settle;

  always_ff @(posedge clk) begin
    if (rst) begin
      qw     <= 32'sh40000000;
      qx     <= '0;
      qy     <= '0;
      qz     <= '0;
      cen[0] <= '0;
      cen[1] <= '0;
      cen[2] <= '0;
      gate   <= 32'd262144;
      settle <= 2'd2;
    end else if (cfg_valid) begin
      settle <= 2'd2;
      case (cfg_index)
        REG_QUAT_W:   qw     <= cfg_data;
        REG_QUAT_X:   qx     <= cfg_data;
        REG_QUAT_Y:   qy     <= cfg_data;
        REG_QUAT_Z:   qz     <= cfg_data;
        REG_CENTER_X: cen[0] <= cfg_data;
        REG_CENTER_Y: cen[1] <= cfg_data;
        REG_CENTER_Z: cen[2] <= cfg_data;
        REG_GATE:     gate   <= cfg_data;
        default: ;
      endcase
    end else if (settle != 2'd0) begin
      settle <= settle - 2'd1;
    end
  end

  // matrix: quaternion products, then entries, each registered
  logic signed [63:0] m01, m02, m03, m11, m12, m13, m22, m23, m33;
  logic signed [34:0] p01, p02, p03, p11, p12, p13, p22, p23, p33;
  logic signed [36:0] e [3][3];
  logic signed [32:0] mat [3][3];
  logic signed [17:0] org_c [3];
  logic signed [17:0] org [3];

  always_comb begin
    m01 = qw * qx;
    m02 = qw * qy;
    m03 = qw * qz;
    m11 = qx * qx;
    m12 = qx * qy;
    m13 = qx * qz;
    m22 = qy * qy;
    m23 = qy * qz;
    m33 = qz * qz;
  end

  always_ff @(posedge clk) begin
    p01 <= 35'(m01 >>> 29);
    p02 <= 35'(m02 >>> 29);
    p03 <= 35'(m03 >>> 29);
    p11 <= 35'(m11 >>> 29);
    p12 <= 35'(m12 >>> 29);
    p13 <= 35'(m13 >>> 29);
    p22 <= 35'(m22 >>> 29);
    p23 <= 35'(m23 >>> 29);
    p33 <= 35'(m33 >>> 29);
  end

  always_comb begin
    e[0][0] = 37'sd1073741824 - (37'(p22) + 37'(p33));
    e[0][1] = 37'(p12) + 37'(p03);
    e[0][2] = 37'(p13) - 37'(p02);
    e[1][0] = 37'(p12) - 37'(p03);
    e[1][1] = 37'sd1073741824 - (37'(p11) + 37'(p33));
    e[1][2] = 37'(p01) + 37'(p23);
    e[2][0] = 37'(p02) + 37'(p13);
    e[2][1] = 37'(p23) - 37'(p01);
    e[2][2] = 37'sd1073741824 - (37'(p11) + 37'(p22));
  end

  // box origin: center rounded half away from zero, minus the half length
  always_comb begin
    logic [32:0] n;
    for (int a = 0; a < 3; a++) begin
      if (cen[a] >= 0) begin
        n = (33'(unsigned'(cen[a])) + 33'h8000) >> 16;
        org_c[a] = 18'(signed'(n[16:0]));
      end else begin
        n = ((33'd0 - 33'(cen[a])) + 33'h8000) >> 16;
        org_c[a] = 18'sd0 - 18'(signed'({1'b0, n[16:0]}));
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) mat[i][j] <= sat_entry(e[i][j]);
      org[i] <= org_c[i] - 18'(HALF_SIDE);
    end
  end

  // pixel pipeline, all stages advance together
  logic               fadv;
  fctl_t              ctl [1:NSTG];
  logic signed [31:0] pv [3];
  logic signed [64:0] prod [3][3];
  logic signed [34:0] term [3][3];
  logic signed [31:0] r3 [3];
  logic signed [31:0] r4 [3];
  logic signed [31:0] r5 [3];
  logic signed [32:0] dif [3];
  logic [32:0]        mag [3];
  logic [65:0]        sqf [3];
  logic [49:0]        sq [3];

  assign fadv     = !q_full;
  assign in_ready = fadv && (settle == 2'd0);

  always_comb begin
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) prod[i][j] = mat[i][j] * pv[j];
    for (int a = 0; a < 3; a++) begin
      dif[a] = 33'(r3[a]) - 33'(cen[a]);
      sqf[a] = 66'(mag[a]) * 66'(mag[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 1; s <= NSTG; s++) ctl[s].valid <= 1'b0;
    end else if (fadv) begin
      ctl[1].valid <= in_valid && in_ready;
      for (int s = 2; s <= NSTG; s++) ctl[s].valid <= ctl[s-1].valid;
    end
    if (fadv) begin
      ctl[1].is_load <= (operation == OP_LOAD);
      ctl[1].addr    <= map_address;
      ctl[1].val     <= map_value;
      for (int s = 2; s <= NSTG; s++) begin
        ctl[s].is_load <= ctl[s-1].is_load;
        ctl[s].addr    <= ctl[s-1].addr;
        ctl[s].val     <= ctl[s-1].val;
      end
      pv[0] <= pix_x;
      pv[1] <= pix_y;
      pv[2] <= pix_z;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) term[i][j] <= 35'(prod[i][j] >>> 30);
        r3[i]  <= sat_word(37'(term[i][0]) + 37'(term[i][1]) + 37'(term[i][2]));
        r4[i]  <= r3[i];
        mag[i] <= dif[i][32] ? 33'(-dif[i]) : 33'(dif[i]);
        r5[i]  <= r4[i];
        sq[i]  <= sqf[i][65:16];
      end
    end
  end

  // last stage: gate test and cell classification
  logic [51:0]        d2;
  logic signed [15:0] base [3];
  logic signed [17:0] rel [3];

  always_comb begin
    d2 = 52'(sq[0]) + 52'(sq[1]) + 52'(sq[2]);
    q_data = '0;
    q_data.is_load = ctl[NSTG].is_load;
    q_data.addr    = ctl[NSTG].addr;
    q_data.val     = ctl[NSTG].val;
    q_data.rej     = d2 > 52'(gate);
    for (int a = 0; a < 3; a++) begin
      base[a] = r5[a][31:16];
      rel[a]  = 18'(base[a]) - org[a];
      q_data.frac[a]  = r5[a][15:0];
      q_data.c0[a]    = COORD_MAX_W'(rel[a][CW-1:0]);
      q_data.ok_lo[a] = (rel[a] >= 18'sd0) && (rel[a] <= 18'(2 * HALF_SIDE));
      q_data.ok_hi[a] = (rel[a] >= -18'sd1) && (rel[a] <= 18'(2 * HALF_SIDE - 1));
    end
    q_push = fadv && ctl[NSTG].valid;
  end

endmodule

// ===== rtl/rptw_queue.sv =====
// Decoupling queue between front and back end, QUEUE_DEPTH entries of qent_t.
// Depends on rptw_pkg.
module rptw_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rptw_pkg::qent_t wdata,
  output logic            full,
  input  logic            pop,
  output logic            nempty,
  output rptw_pkg::qent_t rdata
);
  import rptw_pkg::*;

  qent_t               slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wp, rp;
  logic [QUEUE_AW:0]   cnt;

  assign full   = (cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign nempty = (cnt != '0);
  assign rdata  = slots[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
    end
    if (push) slots[wp] <= wdata;
  end

endmodule

// ===== rtl/rptw_back.sv =====
// Back end: voxel map memory, corner walk, trilinear weights and result buffer.
// Depends on rptw_pkg; reads entries from rptw_queue.
module rptw_back #(
  parameter int HALF_SIDE     = 7,
  parameter int VOXEL_ID_BITS = 12
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_nempty,
  input  rptw_pkg::qent_t q_head,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output rptw_pkg::res_t  out_res
);
  import rptw_pkg::*;

  localparam int BOX_LEN = 2 * HALF_SIDE + 1;
  localparam int BOX_VOL = BOX_LEN * BOX_LEN * BOX_LEN;
  localparam int CW = $clog2(BOX_LEN);
  localparam int AW = $clog2(BOX_VOL);
  localparam logic [AW-1:0] STRIDE_X = AW'(BOX_LEN * BOX_LEN);
  localparam logic [AW-1:0] STRIDE_Y = AW'(BOX_LEN);
  localparam logic [11:0] ID_MASK =
    (VOXEL_ID_BITS >= 12) ? 12'hfff : 12'((1 << VOXEL_ID_BITS) - 1);

  logic signed [12:0] mem [BOX_VOL];

  // result buffer
  res_t              obuf [OUT_DEPTH];
  logic [OUT_AW-1:0] owp, orp;
  logic [OUT_AW:0]   ocnt;
  logic              opush;
  res_t              odata;
  logic              badv;

  assign badv      = (ocnt != (OUT_AW+1)'(OUT_DEPTH));
  assign out_valid = (ocnt != '0);
  assign out_res   = obuf[orp];

  always_ff @(posedge clk) begin
    if (rst) begin
      owp  <= '0;
      orp  <= '0;
      ocnt <= '0;
    end else begin
      if (opush) owp <= owp + 1'b1;
      if (out_valid && out_ready) orp <= orp + 1'b1;
      ocnt <= ocnt + (OUT_AW+1)'(opush) - (OUT_AW+1)'(out_valid && out_ready);
    end
    if (opush) obuf[owp] <= odata;
  end

  // issue: one corner per cycle while the buffer has room, then a closing slot
  logic [3:0]    step;
  logic          iss, iss_flush;
  logic [2:0]    ci;
  logic [CW-1:0] cx, cy, cz;
  logic          inbox;
  logic [16:0]   wx, wy, wz;
  logic [AW-1:0] raddr;

  always_comb begin
    ci        = step[2:0];
    iss       = 1'b0;
    iss_flush = 1'b0;
    q_pop     = 1'b0;
    if (badv && q_nempty) begin
      if (q_head.is_load) begin
        q_pop = 1'b1;
      end else if (q_head.rej || step[3]) begin
        iss       = 1'b1;
        iss_flush = 1'b1;
        q_pop     = 1'b1;
      end else begin
        iss = 1'b1;
      end
    end
    cx = q_head.c0[0][CW-1:0] + CW'(ci[2]);
    cy = q_head.c0[1][CW-1:0] + CW'(ci[1]);
    cz = q_head.c0[2][CW-1:0] + CW'(ci[0]);
    inbox = (ci[2] ? q_head.ok_hi[0] : q_head.ok_lo[0]) &&
            (ci[1] ? q_head.ok_hi[1] : q_head.ok_lo[1]) &&
            (ci[0] ? q_head.ok_hi[2] : q_head.ok_lo[2]);
    wx = ci[2] ? 17'(q_head.frac[0]) : 17'h10000 - 17'(q_head.frac[0]);
    wy = ci[1] ? 17'(q_head.frac[1]) : 17'h10000 - 17'(q_head.frac[1]);
    wz = ci[0] ? 17'(q_head.frac[2]) : 17'h10000 - 17'(q_head.frac[2]);
    raddr = AW'(AW'(cx) * STRIDE_X + AW'(cy) * STRIDE_Y + AW'(cz));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (iss) begin
      step <= iss_flush ? 4'd0 : step + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_head.is_load && (32'(q_head.addr) < BOX_VOL))
      mem[AW'(q_head.addr)] <= q_head.val;
  end

  // corner pipeline
  logic               s1_v, s2_v, s3_v;
  logic               s1_f, s2_f, s3_f;
  logic [2:0]         s1_c, s2_c, s3_c;
  logic               s1_in, s2_keep, s3_keep;
  logic [16:0]        s1_wx, s1_wy, s1_wz, s2_wz;
  logic signed [12:0] s1_id;
  logic [11:0]        s2_id, s3_id;
  logic [33:0]        s2_p;
  logic [50:0]        s3_full;
  logic [16:0]        s3_w;

  assign s3_full = 51'(s2_p) * 51'(s2_wz) + 51'h80000000;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else if (badv) begin
      s1_v <= iss;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
    if (badv) begin
      s1_id   <= mem[raddr];
      s1_f    <= iss_flush;
      s1_c    <= ci;
      s1_in   <= inbox;
      s1_wx   <= wx;
      s1_wy   <= wy;
      s1_wz   <= wz;
      s2_f    <= s1_f;
      s2_c    <= s1_c;
      s2_keep <= s1_in && !s1_id[12];
      s2_id   <= s1_id[11:0] & ID_MASK;
      s2_p    <= 34'(s1_wx) * 34'(s1_wy);
      s2_wz   <= s1_wz;
      s3_f    <= s2_f;
      s3_c    <= s2_c;
      s3_keep <= s2_keep;
      s3_id   <= s2_id;
      s3_w    <= s3_full[48:32];
    end
  end

  // a kept corner waits; the next kept one pushes it, the closing slot sets last
  res_t pend;
  logic pend_v;

  always_comb begin
    opush = 1'b0;
    odata = pend;
    if (badv && s3_v) begin
      if (s3_f) begin
        opush = 1'b1;
        if (pend_v) odata.last = 1'b1;
        else odata = '{hit: 1'b0, voxel_id: '0, weight: '0, corner: '0, last: 1'b1};
      end else if (s3_keep && pend_v) begin
        opush = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v <= 1'b0;
    end else if (badv && s3_v) begin
      if (s3_f) pend_v <= 1'b0;
      else if (s3_keep) pend_v <= 1'b1;
    end
    if (badv && s3_v && !s3_f && s3_keep)
      pend <= '{hit: 1'b1, voxel_id: s3_id, weight: s3_w, corner: s3_c, last: 1'b0};
  end

endmodule

// ===== rtl/rotated_pixel_trilinear_weights.sv =====
// Top level of the rotated pixel trilinear weight block.
// Depends on rptw_pkg, rptw_front, rptw_queue and rptw_back.
//
//  channel   handshake            payload
//  cfg       cfg_valid/cfg_ready  cfg_index, cfg_data
//  in        in_valid/in_ready    operation, map_address, map_value, pix_x/y/z
//  out       out_valid/out_ready  hit, voxel_id, weight, corner, last_of_pixel
//
// A pixel occupies the corner walk for its 8 corners plus a closing slot, or for the
// closing slot alone when gated out; a map load is popped without a slot. Each result
// beat passes the front pipeline, the queue, the corner pipeline and the result buffer.
// The input stays ready while the 4-entry queue has room; it drops after a register
// write, and after reset, while the rotation matrix settles. Reset is synchronous;
// the voxel map is not cleared.
module rotated_pixel_trilinear_weights #(
  parameter int HALF_SIDE     = 7,
  parameter int VOXEL_ID_BITS = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               operation,
  input  logic [11:0]        map_address,
  input  logic signed [12:0] map_value,
  input  logic signed [31:0] pix_x,
  input  logic signed [31:0] pix_y,
  input  logic signed [31:0] pix_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               hit,
  output logic [11:0]        voxel_id,
  output logic [16:0]        weight,
  output logic [2:0]         corner,
  output logic               last_of_pixel
);
  import rptw_pkg::*;

  qent_t qin, qout;
  logic  qpush, qfull, qpop, qnempty;
  res_t  res;

  assign cfg_ready = 1'b1;

  rptw_front #(.HALF_SIDE(HALF_SIDE)) u_front (
    .clk, .rst,
    .cfg_valid(cfg_valid && cfg_ready), .cfg_index, .cfg_data,
    .in_valid, .in_ready, .operation, .map_address, .map_value,
    .pix_x, .pix_y, .pix_z,
    .q_push(qpush), .q_data(qin), .q_full(qfull)
  );

  rptw_queue u_queue (
    .clk, .rst, .push(qpush), .wdata(qin), .full(qfull),
    .pop(qpop), .nempty(qnempty), .rdata(qout)
  );

  rptw_back #(.HALF_SIDE(HALF_SIDE), .VOXEL_ID_BITS(VOXEL_ID_BITS)) u_back (
    .clk, .rst, .q_nempty(qnempty), .q_head(qout), .q_pop(qpop),
    .out_valid, .out_ready, .out_res(res)
  );

  assign hit           = res.hit;
  assign voxel_id      = res.voxel_id;
  assign weight        = res.weight;
  assign corner        = res.corner;
  assign last_of_pixel = res.last;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for rotated_pixel_trilinear_weights.
// Depends on rptw_pkg and the block's RTL. An in-file scoreboard predicts the corner
// beats of every pixel from the register settings and the loaded voxel map.
`timescale 1ns / 1ps

module tb;
  import rptw_pkg::*;

  localparam int BOX_HALF = 7;
  localparam int BOX_SIDE = 2 * BOX_HALF + 1;
  localparam int BOX_VOL  = BOX_SIDE * BOX_SIDE * BOX_SIDE;
  localparam int IDLE_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 24;
  // gate under half a voxel: kept corners stay within one step of the box center
  localparam int GATE_TIGHT = 8000;

  // predicts corner beats per pixel and checks them in order
  class corner_weight_board;
    int        map_ids[BOX_VOL];
    bit [31:0] setting[8];
    res_t      exp_corners[$];
    int        errors, hits, misses, loads, pixels, writes;

    function void write_reg(int idx, bit [31:0] d);
      setting[idx] = d;
      writes++;
    endfunction

    function void note_item(bit op, bit [11:0] addr, bit signed [12:0] val,
                            bit signed [31:0] px, bit signed [31:0] py,
                            bit signed [31:0] pz);
      longint q[4], m[3][3], v[3], c[3], r[3], base[3], org[3];
      longint p01, p02, p03, p11, p12, p13, p22, p23, p33, acc, dd, x0, y0, z0;
      longint unsigned a, d2, cx, cy, cz, w;
      longint unsigned frac[3];
      int cnt, id;
      res_t e;
      if (op == OP_LOAD) begin
        loads++;
        if (addr < BOX_VOL) map_ids[addr] = val;
        return;
      end
      pixels++;
      for (int i = 0; i < 4; i++) q[i] = $signed(setting[i]);
      p01 = (q[0] * q[1]) >>> 29; p02 = (q[0] * q[2]) >>> 29;
      p03 = (q[0] * q[3]) >>> 29; p11 = (q[1] * q[1]) >>> 29;
      p12 = (q[1] * q[2]) >>> 29; p13 = (q[1] * q[3]) >>> 29;
      p22 = (q[2] * q[2]) >>> 29; p23 = (q[2] * q[3]) >>> 29;
      p33 = (q[3] * q[3]) >>> 29;
      m[0][0] = (64'sd1 <<< 30) - (p22 + p33); m[0][1] = p12 + p03; m[0][2] = p13 - p02;
      m[1][0] = p12 - p03; m[1][1] = (64'sd1 <<< 30) - (p11 + p33); m[1][2] = p01 + p23;
      m[2][0] = p02 + p13; m[2][1] = p23 - p01; m[2][2] = (64'sd1 <<< 30) - (p11 + p22);
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          if (m[i][j] < -(64'sd1 <<< 31)) m[i][j] = -(64'sd1 <<< 31);
          if (m[i][j] > (64'sd1 <<< 31)) m[i][j] = 64'sd1 <<< 31;
        end
      v[0] = px; v[1] = py; v[2] = pz;
      for (int i = 0; i < 3; i++) c[i] = $signed(setting[4 + i]);
      d2 = 0;
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int j = 0; j < 3; j++) acc += (m[i][j] * v[j]) >>> 30;
        if (acc < -64'sd2147483648) acc = -64'sd2147483648;
        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
        r[i] = acc;
        dd = r[i] - c[i];
        a = (dd < 0) ? -dd : dd;
        d2 += (a * a) >> 16;
      end
      e = '0;
      e.last = 1'b1;
      if (d2 > {32'b0, setting[7]}) begin
        exp_corners.push_back(e);
        misses++;
        return;
      end
      for (int i = 0; i < 3; i++) begin
        base[i] = r[i] >>> 16;
        frac[i] = r[i] & 64'hFFFF;
        // round half away from zero
        org[i] = (c[i] >= 0) ? ((c[i] + 32768) >>> 16) : -((-c[i] + 32768) >>> 16);
        org[i] -= BOX_HALF;
      end
      cnt = 0;
      for (int i = 0; i < 2; i++)
        for (int j = 0; j < 2; j++)
          for (int k = 0; k < 2; k++) begin
            x0 = base[0] - org[0] + i;
            y0 = base[1] - org[1] + j;
            z0 = base[2] - org[2] + k;
            if (x0 < 0 || x0 >= BOX_SIDE || y0 < 0 || y0 >= BOX_SIDE ||
                z0 < 0 || z0 >= BOX_SIDE) continue;
            id = map_ids[x0 * BOX_SIDE * BOX_SIDE + y0 * BOX_SIDE + z0];
            if (id < 0) continue;
            cx = i ? frac[0] : 65536 - frac[0];
            cy = j ? frac[1] : 65536 - frac[1];
            cz = k ? frac[2] : 65536 - frac[2];
            w = (cx * cy * cz + (64'd1 << 31)) >> 32;
            e.hit = 1'b1;
            e.voxel_id = id[11:0];
            e.weight = w[16:0];
            e.corner = 3'(i * 4 + j * 2 + k);
            e.last = 1'b0;
            exp_corners.push_back(e);
            cnt++;
          end
      if (cnt == 0) begin
        e = '0;
        e.last = 1'b1;
        misses++;
        exp_corners.push_back(e);
      end else begin
        exp_corners[$].last = 1'b1;
        hits += cnt;
      end
    endfunction

    function void check(res_t got);
      res_t e;
      if (exp_corners.size() == 0) begin
        $error("unexpected result beat: hit %0d voxel %0d weight %0d", got.hit,
               got.voxel_id, got.weight);
        errors++;
        return;
      end
      e = exp_corners.pop_front();
      if (got.hit !== e.hit) begin
        $error("hit: expected %0d, got %0d", e.hit, got.hit); errors++;
      end
      if (got.voxel_id !== e.voxel_id) begin
        $error("voxel_id: expected %0d, got %0d", e.voxel_id, got.voxel_id); errors++;
      end
      if (got.weight !== e.weight) begin
        $error("weight: expected %0d, got %0d", e.weight, got.weight); errors++;
      end
      if (got.corner !== e.corner) begin
        $error("corner: expected %0d, got %0d", e.corner, got.corner); errors++;
      end
      if (got.last !== e.last) begin
        $error("last_of_pixel: expected %0d, got %0d", e.last, got.last); errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [3:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               operation = OP_LOAD;
  logic [11:0]        map_address = '0;
  logic signed [12:0] map_value = '0;
  logic signed [31:0] pix_x = '0, pix_y = '0, pix_z = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               hit;
  logic [11:0]        voxel_id;
  logic [16:0]        weight;
  logic [2:0]         corner;
  logic               last_of_pixel;

  corner_weight_board sb = new();
  int burst_left = 0;
  int idle_cycles = 0;

  rotated_pixel_trilinear_weights dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver stall pattern: free-running, lightly and heavily stalled stretches
  int stall_mode = 0, stall_count = 0;
  always @(negedge clk) begin
    if (stall_count == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_count <= $urandom_range(16, 96);
    end else begin
      stall_count <= stall_count - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 0);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    res_t got;
    if (!rst && out_valid && out_ready) begin
      got.hit = hit;
      got.voxel_id = voxel_id;
      got.weight = weight;
      got.corner = corner;
      got.last = last_of_pixel;
      sb.check(got);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  function automatic int box_addr(int x, int y, int z);
    return x * BOX_SIDE * BOX_SIDE + y * BOX_SIDE + z;
  endfunction

  // sender with bursts and random gaps
  task automatic send_item(bit op, bit [11:0] addr, bit signed [12:0] val,
                           bit signed [31:0] px, bit signed [31:0] py,
                           bit signed [31:0] pz);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        @(negedge clk) in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    operation <= op;
    map_address <= addr;
    map_value <= val;
    pix_x <= px;
    pix_y <= py;
    pix_z <= pz;
    do @(posedge clk); while (!in_ready);
    sb.note_item(op, addr, val, px, py, pz);
  endtask

  task automatic load(int addr, int val);
    send_item(OP_LOAD, 12'(addr), 13'(val), $urandom, $urandom, $urandom);
  endtask

  task automatic pixel(bit signed [31:0] px, bit signed [31:0] py, bit signed [31:0] pz);
    send_item(OP_PIXEL, 12'($urandom), 13'($urandom), px, py, pz);
  endtask

  task automatic drain();
    @(negedge clk) in_valid <= 1'b0;
    burst_left = 0;
    while (sb.exp_corners.size() != 0) @(posedge clk);
    // loads give no beat; let the pipe empty
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, bit [31:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, d);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic write_all(bit [31:0] w, bit [31:0] x, bit [31:0] y, bit [31:0] z,
                           bit [31:0] cx, bit [31:0] cy, bit [31:0] cz, bit [31:0] g);
    drain();
    write_reg(REG_QUAT_W, w);
    write_reg(REG_QUAT_X, x);
    write_reg(REG_QUAT_Y, y);
    write_reg(REG_QUAT_Z, z);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_GATE, g);
  endtask

  function automatic bit [31:0] to_q16(real v);
    real s;
    s = v * 65536.0;
    if (s > 2147483647.0) s = 2147483647.0;
    if (s < -2147483648.0) s = -2147483648.0;
    return $rtoi(s);
  endfunction

  // pixel that lands near target (voxel units): inverse rotation by transpose
  task automatic aimed_pixel(real span);
    real qw, qx, qy, qz, t[3], m[3][3], p[3];
    qw = $itor($signed(sb.setting[0])) / 1073741824.0;
    qx = $itor($signed(sb.setting[1])) / 1073741824.0;
    qy = $itor($signed(sb.setting[2])) / 1073741824.0;
    qz = $itor($signed(sb.setting[3])) / 1073741824.0;
    m[0][0] = 1 - 2 * (qy * qy + qz * qz); m[0][1] = 2 * (qx * qy + qw * qz);
    m[0][2] = 2 * (qx * qz - qw * qy);     m[1][0] = 2 * (qx * qy - qw * qz);
    m[1][1] = 1 - 2 * (qx * qx + qz * qz); m[1][2] = 2 * (qy * qz + qw * qx);
    m[2][0] = 2 * (qx * qz + qw * qy);     m[2][1] = 2 * (qy * qz - qw * qx);
    m[2][2] = 1 - 2 * (qx * qx + qy * qy);
    for (int i = 0; i < 3; i++)
      t[i] = $itor($signed(sb.setting[4 + i])) / 65536.0 +
             span * ($itor($urandom_range(0, 20000)) - 10000.0) / 10000.0;
    for (int j = 0; j < 3; j++) begin
      p[j] = 0.0;
      for (int i = 0; i < 3; i++) p[j] += m[i][j] * t[i];
    end
    pixel(to_q16(p[0]), to_q16(p[1]), to_q16(p[2]));
  endtask

  task automatic random_quat(output bit [31:0] q[4]);
    real a[4], n;
    n = 0.0;
    for (int i = 0; i < 4; i++) begin
      a[i] = $itor($urandom_range(0, 2000)) - 1000.0;
      n += a[i] * a[i];
    end
    if (n == 0.0) begin a[0] = 1.0; n = 1.0; end
    for (int i = 0; i < 4; i++) q[i] = $rtoi(a[i] / $sqrt(n) * 1073741824.0);
  endtask

  task automatic random_items(int n);
    int sel;
    real gr;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) drain();
      gr = $sqrt($itor(sb.setting[7]) / 65536.0);
      if (gr > 8.0) gr = 8.0;
      sel = $urandom_range(0, 99);
      if (sel < 15) load($urandom_range(0, 4095), $urandom);
      else if (sel < 25) pixel($urandom, $urandom, $urandom);
      else if (sel < 45) aimed_pixel(9.0);
      else aimed_pixel(gr * 0.6 + 0.01);
    end
  endtask

  initial begin
    bit [31:0] q[4];
    sb.setting[0] = 32'h4000_0000;
    sb.setting[7] = 32'd262144;
    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // the map is not cleared by reset: with the tight gate only the central
    // 3x3x3 entries are ever read, so those are filled first
    write_reg(REG_GATE, GATE_TIGHT);
    for (int i = BOX_HALF - 1; i <= BOX_HALF + 1; i++)
      for (int j = BOX_HALF - 1; j <= BOX_HALF + 1; j++)
        for (int k = BOX_HALF - 1; k <= BOX_HALF + 1; k++)
          load(box_addr(i, j, k), ($urandom_range(0, 3) == 0) ?
               -$urandom_range(1, 4096) : $urandom_range(0, 4095));

    // identity rotation, center at the origin
    load(box_addr(BOX_HALF, BOX_HALF, BOX_HALF), -1);
    pixel(0, 0, 0);
    load(box_addr(BOX_HALF, BOX_HALF, BOX_HALF), 4095);
    pixel(0, 0, 0);
    load(4095, 100);
    load(BOX_VOL, 5);
    pixel(32'h0000_2000, 32'h0000_1000, -32'sh0000_3000);
    pixel(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
    pixel(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    load(box_addr(BOX_HALF + 1, BOX_HALF, BOX_HALF), -4096);
    pixel(32'h0000_4000, 32'h0000_2000, 32'h0000_1000);
    pixel(-32'sh0000_0001, -32'sh0000_0001, 0);

    // a cell with no voxel at any corner
    for (int i = BOX_HALF; i <= BOX_HALF + 1; i++)
      for (int j = BOX_HALF; j <= BOX_HALF + 1; j++)
        for (int k = BOX_HALF; k <= BOX_HALF + 1; k++) load(box_addr(i, j, k), -1);
    pixel(32'h0000_1000, 32'h0000_1000, 32'h0000_1000);
    random_items(10);

    // quarter turn about z, off-center box
    write_all(32'd759250125, 0, 0, 32'd759250125, 32'h0003_8000, -32'sh0002_4000,
              32'h000A_C000, 32'd6000);
    random_items(20);

    random_quat(q);
    write_all(q[0], q[1], q[2], q[3], $urandom_range(0, 13107200) - 6553600,
              $urandom_range(0, 13107200) - 6553600, $urandom_range(0, 13107200) - 6553600,
              $urandom_range(0, GATE_TIGHT));
    random_items(20);

    // extreme registers: non-unit quaternion saturates the matrix
    write_all(32'hC000_0000, 32'h4000_0000, 32'hC000_0000, 32'h4000_0000,
              32'h8000_0000, 32'h7FFF_FFFF, 0, GATE_TIGHT);
    random_items(10);

    write_all(32'h4000_0000, 0, 0, 0, 0, 0, 0, 0);
    pixel(0, 0, 0);
    random_items(6);

    random_quat(q);
    write_all(q[0], q[1], q[2], q[3], $urandom, $urandom, $urandom,
              $urandom_range(0, GATE_TIGHT));
    random_items(15);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (sb.exp_corners.size() != 0) begin
      $error("missing result beat: hit %0d voxel %0d weight %0d",
             sb.exp_corners[0].hit, sb.exp_corners[0].voxel_id, sb.exp_corners[0].weight);
      void'(sb.exp_corners.pop_front());
      sb.errors++;
    end
    $display("covered %0d pixels and %0d map loads over %0d register writes",
             sb.pixels, sb.loads, sb.writes);
    $display("checked %0d hit beats and %0d no-hit beats, %0d errors",
             sb.hits, sb.misses, sb.errors);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rptw_pkg.sv
rtl/rptw_front.sv
rtl/rptw_queue.sv
rtl/rptw_back.sv
rtl/rotated_pixel_trilinear_weights.sv
tb/tb.sv
